// ----- hdl/u16550_pkg.sv -----
// ----------------------------------------------------------------------------
// u16550_pkg
// Shared types and constants of the 16550A register model.
// ----------------------------------------------------------------------------
package u16550_pkg;

   localparam int FifoDepthDefault = 16;
   localparam logic [15:0] TimeoutTicksReset = 16'd40;

   typedef enum logic [2:0] {
      REQ_READ  = 3'd0,
      REQ_WRITE = 3'd1,
      REQ_LINE  = 3'd2,
      REQ_BREAK = 3'd3,
      REQ_TICK  = 3'd4
   } req_kind_type;

   typedef enum logic [2:0] {
      ADDR_RBR = 3'd0,
      ADDR_IER = 3'd1,
      ADDR_IIR = 3'd2,
      ADDR_LCR = 3'd3,
      ADDR_MCR = 3'd4,
      ADDR_LSR = 3'd5,
      ADDR_MSR = 3'd6,
      ADDR_SCR = 3'd7
   } reg_addr_type;

   localparam logic [7:0] LSR_DR      = 8'h01;
   localparam logic [7:0] LSR_OE      = 8'h02;
   localparam logic [7:0] LSR_BI      = 8'h10;
   localparam logic [7:0] LSR_THRE    = 8'h20;
   localparam logic [7:0] LSR_TEMT    = 8'h40;
   localparam logic [7:0] LSR_INT_ANY = 8'h1E;
   localparam logic [7:0] FCR_FE      = 8'h01;
   localparam logic [7:0] FCR_RFR     = 8'h02;
   localparam logic [7:0] FCR_XFR     = 8'h04;
   localparam logic [7:0] FCR_MASK    = 8'hC9;
   localparam logic [7:0] IIR_FIFO    = 8'hC0;
   localparam logic [7:0] IIR_HIGH    = 8'hF0;
   localparam logic [3:0] IIR_NONE    = 4'h1;
   localparam logic [3:0] IIR_LINE    = 4'h6;
   localparam logic [3:0] IIR_TIMEOUT = 4'hC;
   localparam logic [3:0] IIR_RXDATA  = 4'h4;
   localparam logic [3:0] IIR_THRE    = 4'h2;
   localparam logic [3:0] IIR_MODEM   = 4'h0;
   localparam logic [4:0] MCR_LOOP    = 5'h10;
   localparam logic [4:0] MCR_RESET   = 5'h08;
   localparam logic [7:0] MSR_RESET   = 8'hB0;
   localparam logic [7:0] LCR_DLAB    = 8'h80;
   localparam logic [15:0] DIV_RESET  = 16'h000C;
   localparam logic [3:0] TRIG_RESET  = 4'd14;

endpackage

// ----- hdl/uart_16550_register_model_top.sv -----
// ----------------------------------------------------------------------------
// uart_16550_register_model_top
// 16550A register model: bus access, line bytes, breaks and ticks.
// ----------------------------------------------------------------------------
// One item is accepted per cycle and its result appears in the output register
// in the next cycle; items flow back to back as long as the result side takes
// them. The receive and transmit FIFOs sit in synchronous RAMs with a registered
// read; the FIFO pointers and all UART registers are flops updated in the
// cycle of the transfer. Receive FIFO writes are registered before the RAM (a
// looped-back byte comes from the transmit RAM read), with forwarding to a
// head read that hits the same entry.
module uart_16550_register_model_top #(
   parameter int FIFO_DEPTH = u16550_pkg::FifoDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_type,
   input  logic [2:0]  req_reg_addr,
   input  logic [7:0]  req_write_data,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_irq,
   output logic        rsp_tx_valid,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_break_out,
   output logic [4:0]  rsp_rx_space,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);

   localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CW = $clog2(FIFO_DEPTH + 1);
   localparam logic [CW:0] DEPTH_W = (CW+1)'(FIFO_DEPTH);
   localparam logic [CW-1:0] DEPTH_C = CW'(FIFO_DEPTH);

   // state
   logic [15:0]   ticks_ff;
   logic [CW-1:0] rx_cnt_ff, rx_cnt_in, tx_cnt_ff, tx_cnt_in;
   logic [AW-1:0] rx_head_ff, rx_head_in, tx_head_ff, tx_head_in;
   logic [7:0]    rbr_ff, rbr_in, thr_ff, thr_in;
   logic [3:0]    ier_ff, ier_in;
   logic [7:0]    iir_ff, iir_in, lcr_ff, lcr_in, lsr_ff, lsr_in, fcr_ff, fcr_in;
   logic [4:0]    mcr_ff, mcr_in;
   logic [7:0]    msr_ff, msr_in, scr_ff, scr_in;
   logic [15:0]   div_ff, div_in;
   logic [3:0]    trig_ff, trig_in;
   logic          thrp_ff, thrp_in, top_ff, top_in;
   logic [15:0]   toc_ff, toc_in;

   // memories
   logic [7:0]    rx_mem [FIFO_DEPTH];
   logic [7:0]    tx_mem [FIFO_DEPTH];
   logic [7:0]    rx_rdata_ff, tx_rdata_ff;

   // delayed receive FIFO write
   logic          pw_v_ff;
   logic [AW-1:0] pw_addr_ff;
   logic          pw_mem_ff;
   logic [7:0]    pw_data_ff;
   logic [7:0]    pw_wdata;

   // output register
   logic       ov_ff;
   logic [7:0] rd_val_ff;
   logic       rd_mem_ff, rd_fwd_ff;
   logic [7:0] rd_fwd_data_ff;
   logic       irq_ff, txv_ff, tx_mem_sel_ff, brk_ff;
   logic [7:0] txb_ff;
   logic [4:0] space_ff;

   // combinational results
   logic          acc;
   logic [7:0]    rd_val;
   logic          rd_mem, sent, shift_mem;
   logic          rx_re, tx_re, tx_we, rxw_v, rxw_mem;
   logic [AW-1:0] rx_raddr, tx_raddr, tx_waddr, rxw_addr;
   logic [7:0]    rxw_data;
   logic [4:0]    space;

   assign req_ready = !ov_ff || rsp_ready;
   assign acc = req_valid && req_ready;
   assign pw_wdata = pw_mem_ff ? tx_rdata_ff : pw_data_ff;

   function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] h, input logic [CW-1:0] c);
      logic [CW:0] s;
      s = (CW+1)'(h) + (CW+1)'(c);
      if (s >= DEPTH_W) begin
         s = s - DEPTH_W;
      end
      return s[AW-1:0];
   endfunction

   always_comb begin
      logic [7:0] v;
      logic [3:0] id;
      logic       fe;
      rx_cnt_in = rx_cnt_ff;  rx_head_in = rx_head_ff;
      tx_cnt_in = tx_cnt_ff;  tx_head_in = tx_head_ff;
      rbr_in = rbr_ff;  thr_in = thr_ff;  ier_in = ier_ff;  iir_in = iir_ff;
      lcr_in = lcr_ff;  lsr_in = lsr_ff;  fcr_in = fcr_ff;  mcr_in = mcr_ff;
      msr_in = msr_ff;  scr_in = scr_ff;  div_in = div_ff;  trig_in = trig_ff;
      thrp_in = thrp_ff;  top_in = top_ff;  toc_in = toc_ff;
      rd_val = 8'h00;  rd_mem = 1'b0;  sent = 1'b0;  shift_mem = 1'b0;
      rx_re = 1'b0;  rx_raddr = rx_head_ff;
      tx_re = 1'b0;  tx_raddr = tx_head_ff;
      tx_we = 1'b0;  tx_waddr = tx_head_ff;
      rxw_v = 1'b0;  rxw_mem = 1'b0;  rxw_addr = rx_head_ff;  rxw_data = 8'h00;
      v = req_write_data;
      id = u16550_pkg::IIR_NONE;
      fe = fcr_ff[0];

      case (req_type)
         u16550_pkg::REQ_READ: begin
            unique case (req_reg_addr)
               u16550_pkg::ADDR_RBR: begin
                  if (lcr_ff[7]) begin
                     rd_val = div_ff[7:0];
                  end else if (fe) begin
                     if (rx_cnt_ff != '0) begin
                        rd_mem = 1'b1;
                        rx_re = 1'b1;
                        rx_head_in = wrap_add(rx_head_ff, CW'(1));
                        rx_cnt_in = rx_cnt_ff - 1'b1;
                     end
                     if (rx_cnt_in == '0) begin
                        lsr_in = lsr_in & ~(u16550_pkg::LSR_DR | u16550_pkg::LSR_BI);
                     end else begin
                        toc_in = ticks_ff;
                     end
                     top_in = 1'b0;
                  end else begin
                     rd_val = rbr_ff;
                     lsr_in = lsr_in & ~(u16550_pkg::LSR_DR | u16550_pkg::LSR_BI);
                  end
               end
               u16550_pkg::ADDR_IER: rd_val = lcr_ff[7] ? div_ff[15:8] : {4'h0, ier_ff};
               u16550_pkg::ADDR_IIR: begin
                  rd_val = iir_ff;
                  if (iir_ff[2:1] == 2'b01) begin
                     thrp_in = 1'b0;
                  end
               end
               u16550_pkg::ADDR_LCR: rd_val = lcr_ff;
               u16550_pkg::ADDR_MCR: rd_val = {3'b000, mcr_ff};
               u16550_pkg::ADDR_LSR: begin
                  rd_val = lsr_ff;
                  lsr_in = lsr_ff & ~(u16550_pkg::LSR_BI | u16550_pkg::LSR_OE);
               end
               u16550_pkg::ADDR_MSR: begin
                  if (mcr_ff[4]) begin
                     rd_val = {mcr_ff[3:2], mcr_ff[0], mcr_ff[1], 4'h0};
                  end else begin
                     rd_val = msr_ff;
                     msr_in = msr_ff & u16550_pkg::IIR_HIGH;
                  end
               end
               default: rd_val = scr_ff;
            endcase
         end
         u16550_pkg::REQ_WRITE: begin
            unique case (req_reg_addr)
               u16550_pkg::ADDR_RBR: begin
                  if (lcr_ff[7]) begin
                     div_in = {div_ff[15:8], req_write_data};
                  end else begin
                     thr_in = req_write_data;
                     thrp_in = 1'b0;
                     lsr_in = lsr_in & ~u16550_pkg::LSR_THRE;
                     if (fe) begin
                        if (tx_cnt_ff >= DEPTH_C) begin
                           tx_head_in = wrap_add(tx_head_ff, CW'(1));
                           tx_cnt_in = tx_cnt_ff - 1'b1;
                        end
                        tx_we = 1'b1;
                        tx_waddr = wrap_add(tx_head_in, tx_cnt_in);
                        lsr_in = lsr_in & ~u16550_pkg::LSR_TEMT;
                        // pop: an empty FIFO before the push means the head is this byte
                        shift_mem = (tx_cnt_in != '0);
                        tx_re = shift_mem;
                        tx_raddr = tx_head_in;
                        tx_head_in = wrap_add(tx_head_in, CW'(1));
                        // push and pop leave the count unchanged
                        if (tx_cnt_in == '0) begin
                           lsr_in = lsr_in | u16550_pkg::LSR_THRE;
                        end
                     end else begin
                        lsr_in = (lsr_in | u16550_pkg::LSR_THRE) & ~u16550_pkg::LSR_TEMT;
                     end
                     if (mcr_ff[4]) begin
                        if (fe) begin
                           if (rx_cnt_ff < DEPTH_C) begin
                              rxw_v = 1'b1;
                              rxw_mem = shift_mem;
                              rxw_data = req_write_data;
                              rxw_addr = wrap_add(rx_head_ff, rx_cnt_ff);
                              rx_cnt_in = rx_cnt_ff + 1'b1;
                           end else begin
                              lsr_in = lsr_in | u16550_pkg::LSR_OE;
                           end
                           toc_in = ticks_ff;
                        end else begin
                           if (lsr_ff[0]) begin
                              lsr_in = lsr_in | u16550_pkg::LSR_OE;
                           end
                           rbr_in = req_write_data;
                        end
                        lsr_in = lsr_in | u16550_pkg::LSR_DR;
                     end else begin
                        sent = 1'b1;
                     end
                     if (lsr_in[5]) begin
                        lsr_in = lsr_in | u16550_pkg::LSR_TEMT;
                        thrp_in = 1'b1;
                     end
                  end
               end
               u16550_pkg::ADDR_IER: begin
                  if (lcr_ff[7]) begin
                     div_in = {req_write_data, div_ff[7:0]};
                  end else begin
                     ier_in = req_write_data[3:0];
                     if (lsr_ff[5]) begin
                        thrp_in = 1'b1;
                     end
                  end
               end
               u16550_pkg::ADDR_IIR: begin
                  if (v != fcr_ff) begin
                     if (v[0] != fcr_ff[0]) begin
                        v = v | u16550_pkg::FCR_XFR | u16550_pkg::FCR_RFR;
                     end
                     if (v[1]) begin
                        toc_in = '0;
                        top_in = 1'b0;
                        rx_cnt_in = '0;
                        rx_head_in = '0;
                        lsr_in = lsr_in & ~(u16550_pkg::LSR_DR | u16550_pkg::LSR_BI);
                     end
                     if (v[2]) begin
                        tx_cnt_in = '0;
                        tx_head_in = '0;
                     end
                     if (v[0]) begin
                        iir_in = iir_ff | u16550_pkg::IIR_FIFO;
                        case (v[7:6])
                           2'b00:   trig_in = 4'd1;
                           2'b01:   trig_in = 4'd4;
                           2'b10:   trig_in = 4'd8;
                           default: trig_in = 4'd14;
                        endcase
                     end else begin
                        iir_in = iir_ff & ~u16550_pkg::IIR_FIFO;
                     end
                     fcr_in = v & u16550_pkg::FCR_MASK;
                  end
               end
               u16550_pkg::ADDR_LCR: lcr_in = req_write_data;
               u16550_pkg::ADDR_MCR: mcr_in = req_write_data[4:0];
               u16550_pkg::ADDR_SCR: scr_in = req_write_data;
               default: ;
            endcase
         end
         u16550_pkg::REQ_LINE: begin
            if (fe) begin
               if (rx_cnt_ff < DEPTH_C) begin
                  rxw_v = 1'b1;
                  rxw_data = req_rx_byte;
                  rxw_addr = wrap_add(rx_head_ff, rx_cnt_ff);
                  rx_cnt_in = rx_cnt_ff + 1'b1;
               end else begin
                  lsr_in = lsr_in | u16550_pkg::LSR_OE;
               end
               toc_in = ticks_ff;
            end else begin
               if (lsr_ff[0]) begin
                  lsr_in = lsr_in | u16550_pkg::LSR_OE;
               end
               rbr_in = req_rx_byte;
            end
            lsr_in = lsr_in | u16550_pkg::LSR_DR;
         end
         u16550_pkg::REQ_BREAK: begin
            rbr_in = 8'h00;
            if (rx_cnt_ff < DEPTH_C) begin
               rxw_v = 1'b1;
               rxw_addr = wrap_add(rx_head_ff, rx_cnt_ff);
               rx_cnt_in = rx_cnt_ff + 1'b1;
            end else begin
               lsr_in = lsr_in | u16550_pkg::LSR_OE;
            end
            lsr_in = lsr_in | u16550_pkg::LSR_BI | u16550_pkg::LSR_DR;
         end
         u16550_pkg::REQ_TICK: begin
            if (toc_ff != '0) begin
               toc_in = toc_ff - 1'b1;
               if (toc_in == '0 && rx_cnt_ff != '0) begin
                  top_in = 1'b1;
               end
            end
         end
         default: ;
      endcase

      // prioritized interrupt identity
      if (ier_in[2] && (lsr_in & u16550_pkg::LSR_INT_ANY) != 8'h00) begin
         id = u16550_pkg::IIR_LINE;
      end else if (ier_in[0] && top_in) begin
         id = u16550_pkg::IIR_TIMEOUT;
      end else if (ier_in[0] && lsr_in[0] &&
                   (!fcr_in[0] || rx_cnt_in >= CW'(trig_in))) begin
         id = u16550_pkg::IIR_RXDATA;
      end else if (ier_in[1] && thrp_in) begin
         id = u16550_pkg::IIR_THRE;
      end else if (ier_in[3] && msr_in[3:0] != 4'h0) begin
         id = u16550_pkg::IIR_MODEM;
      end
      iir_in = (iir_in & u16550_pkg::IIR_HIGH) | {4'h0, id};

      if (fcr_in[0]) begin
         if (rx_cnt_in >= DEPTH_C) begin
            space = 5'd0;
         end else if (rx_cnt_in <= CW'(trig_in)) begin
            space = 5'(trig_in) - 5'(rx_cnt_in);
         end else begin
            space = 5'd1;
         end
      end else begin
         space = lsr_in[0] ? 5'd0 : 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff <= u16550_pkg::TimeoutTicksReset;
         rx_cnt_ff <= '0;  rx_head_ff <= '0;  tx_cnt_ff <= '0;  tx_head_ff <= '0;
         rbr_ff <= '0;  thr_ff <= '0;  ier_ff <= '0;  iir_ff <= 8'h01;
         lcr_ff <= '0;  lsr_ff <= u16550_pkg::LSR_TEMT | u16550_pkg::LSR_THRE;
         fcr_ff <= '0;  mcr_ff <= u16550_pkg::MCR_RESET;
         msr_ff <= u16550_pkg::MSR_RESET;  scr_ff <= '0;
         div_ff <= u16550_pkg::DIV_RESET;  trig_ff <= u16550_pkg::TRIG_RESET;
         thrp_ff <= 1'b0;  top_ff <= 1'b0;  toc_ff <= '0;
         pw_v_ff <= 1'b0;  ov_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            ticks_ff <= csr_write_data;
         end
         pw_v_ff <= acc && rxw_v;
         if (acc) begin
            rx_cnt_ff <= rx_cnt_in;  rx_head_ff <= rx_head_in;
            tx_cnt_ff <= tx_cnt_in;  tx_head_ff <= tx_head_in;
            rbr_ff <= rbr_in;  thr_ff <= thr_in;  ier_ff <= ier_in;  iir_ff <= iir_in;
            lcr_ff <= lcr_in;  lsr_ff <= lsr_in;  fcr_ff <= fcr_in;  mcr_ff <= mcr_in;
            msr_ff <= msr_in;  scr_ff <= scr_in;  div_ff <= div_in;  trig_ff <= trig_in;
            thrp_ff <= thrp_in;  top_ff <= top_in;  toc_ff <= toc_in;
            ov_ff <= 1'b1;
         end else if (rsp_ready) begin
            ov_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pw_addr_ff <= rxw_addr;
      pw_mem_ff <= rxw_mem;
      pw_data_ff <= rxw_data;
      if (acc) begin
         rd_val_ff <= rd_val;
         rd_mem_ff <= rd_mem;
         // head read hitting the entry written this cycle
         rd_fwd_ff <= pw_v_ff && (pw_addr_ff == rx_raddr);
         rd_fwd_data_ff <= pw_wdata;
         irq_ff <= !iir_in[0];
         txv_ff <= sent;
         tx_mem_sel_ff <= shift_mem;
         txb_ff <= req_write_data;
         brk_ff <= lcr_in[6];
         space_ff <= space;
      end
   end

   always_ff @(posedge clock) begin
      if (pw_v_ff) begin
         rx_mem[pw_addr_ff] <= pw_wdata;
      end
      if (acc && rx_re) begin
         rx_rdata_ff <= rx_mem[rx_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (acc && tx_we) begin
         tx_mem[tx_waddr] <= req_write_data;
      end
      if (acc && tx_re) begin
         tx_rdata_ff <= tx_mem[tx_raddr];
      end
   end

   assign rsp_valid = ov_ff;
   assign rsp_read_data = rd_mem_ff ? (rd_fwd_ff ? rd_fwd_data_ff : rx_rdata_ff) : rd_val_ff;
   assign rsp_irq = irq_ff;
   assign rsp_tx_valid = txv_ff;
   assign rsp_tx_byte = txv_ff ? (tx_mem_sel_ff ? tx_rdata_ff : txb_ff) : 8'h00;
   assign rsp_break_out = brk_ff;
   assign rsp_rx_space = space_ff;

endmodule

// ----- hdl/u16550_checker.sv -----
// ----------------------------------------------------------------------------
// u16550_checker
// Port-level checks of the 16550A register model.
// ----------------------------------------------------------------------------
module u16550_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_tx_valid,
   input logic [7:0] rsp_tx_byte,
   input logic [4:0] rsp_rx_space
);

   // a pending result that is not taken stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // every input transfer yields a result next cycle
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("transfer without result");

   a_tx_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_tx_valid |-> rsp_tx_byte == 8'h00)
      else $error("tx byte without tx valid");

   a_space: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_rx_space <= 5'd16)
      else $error("rx space out of range");

endmodule

bind uart_16550_register_model_top u16550_checker u_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_tx_valid(rsp_tx_valid),
   .rsp_tx_byte(rsp_tx_byte), .rsp_rx_space(rsp_rx_space)
);

// ----- dv/tb_uart_16550_register_model_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_uart_16550_register_model_top
// Self-checking bench for the 16550A register model: a directed table of bus
// accesses, line bytes, breaks and ticks, then random traffic under several
// idle and stall patterns, each transfer checked against a built-in UART model.
// ----------------------------------------------------------------------------
module tb_uart_16550_register_model_top;

   localparam int          Depth      = 16;
   localparam int          CycleLimit = 400000;
   localparam int          SettleGap  = 6;
   localparam logic [2:0]  REQ_SPARE_FIRST = 3'd5;
   localparam logic [2:0]  REQ_SPARE_LAST  = 3'd7;

   typedef struct {
      logic [7:0] rd;
      logic       irq;
      logic       txv;
      logic [7:0] txb;
      logic       brk;
      logic [4:0] space;
   } uart_rsp_type;

   typedef struct {
      logic [2:0] kind;
      logic [2:0] addr;
      logic [7:0] wd;
      logic [7:0] rb;
      bit         typed;
      logic [7:0] typed_rd;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_type = '0;
   logic [2:0]  req_reg_addr = '0;
   logic [7:0]  req_write_data = '0;
   logic [7:0]  req_rx_byte = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_read_data;
   logic        rsp_irq;
   logic        rsp_tx_valid;
   logic [7:0]  rsp_tx_byte;
   logic        rsp_break_out;
   logic [4:0]  rsp_rx_space;
   logic        csr_write_enable = 1'b0;
   logic [15:0] csr_write_data = '0;

   uart_16550_register_model_top #(.FIFO_DEPTH(Depth)) uut (.*);

   always #5 clock = ~clock;

   // ---- UART model state ----
   logic [7:0]  rxq[Depth];
   logic [7:0]  txq[Depth];
   int          rx_cnt, rx_hd, tx_cnt, tx_hd, trig, to_cnt;
   logic [7:0]  rbr, thr, tsr, ier, iir, lcr, lsr, fcr, mcr, msr, scr;
   logic [15:0] dll, to_ticks;
   bit          thr_pend, to_pend;

   uart_rsp_type pending_rsp[$];
   int          fails = 0, n_items = 0, n_rsp = 0, n_tx = 0, n_irq = 0;
   int          idle_pct = 0, stall_pct = 0, hold_len = 0, hold_cnt = 0, cycles = 0;
   bit          chk_rd_en = 0;
   logic [7:0]  chk_rd = '0;

   function void model_reset();
      for (int i = 0; i < Depth; i++) begin
         rxq[i] = '0;
         txq[i] = '0;
      end
      rx_cnt = 0; rx_hd = 0; tx_cnt = 0; tx_hd = 0; to_cnt = 0;
      rbr = '0; thr = '0; tsr = '0; ier = '0; iir = 8'h01; lcr = '0;
      lsr = u16550_pkg::LSR_TEMT | u16550_pkg::LSR_THRE; fcr = '0;
      mcr = 8'(u16550_pkg::MCR_RESET); msr = u16550_pkg::MSR_RESET;
      scr = '0; dll = u16550_pkg::DIV_RESET; trig = u16550_pkg::TRIG_RESET;
      thr_pend = 0; to_pend = 0;
      to_ticks = u16550_pkg::TimeoutTicksReset;
   endfunction

   function void rx_push(logic [7:0] b);
      if (rx_cnt < Depth) begin
         rxq[(rx_hd + rx_cnt) % Depth] = b;
         rx_cnt++;
      end else lsr |= u16550_pkg::LSR_OE;
   endfunction

   function void line_in(logic [7:0] b);
      if (fcr & u16550_pkg::FCR_FE) begin
         rx_push(b);
         lsr |= u16550_pkg::LSR_DR;
         to_cnt = to_ticks;
      end else begin
         if (lsr & u16550_pkg::LSR_DR) lsr |= u16550_pkg::LSR_OE;
         rbr = b;
         lsr |= u16550_pkg::LSR_DR;
      end
   endfunction

   function void eval_irq();
      logic [3:0] id;
      id = u16550_pkg::IIR_NONE;
      if (ier[2] && (lsr & u16550_pkg::LSR_INT_ANY)) id = u16550_pkg::IIR_LINE;
      else if (ier[0] && to_pend) id = u16550_pkg::IIR_TIMEOUT;
      else if (ier[0] && (lsr & u16550_pkg::LSR_DR) &&
               (!(fcr & u16550_pkg::FCR_FE) || rx_cnt >= trig))
         id = u16550_pkg::IIR_RXDATA;
      else if (ier[1] && thr_pend) id = u16550_pkg::IIR_THRE;
      else if (ier[3] && msr[3:0] != 0) id = u16550_pkg::IIR_MODEM;
      iir = {iir[7:4], id};
   endfunction

   // returns 1 when a byte leaves on the line (not looped back)
   function bit shift_out();
      if (fcr & u16550_pkg::FCR_FE) begin
         if (tx_cnt == 0) tsr = '0;
         else begin
            tsr = txq[tx_hd];
            tx_hd = (tx_hd + 1) % Depth;
            tx_cnt--;
         end
         if (tx_cnt == 0) lsr |= u16550_pkg::LSR_THRE;
      end else if (lsr & u16550_pkg::LSR_THRE) return 0;
      else begin
         tsr = thr;
         lsr |= u16550_pkg::LSR_THRE;
         lsr &= ~u16550_pkg::LSR_TEMT;
      end
      if (lsr & u16550_pkg::LSR_THRE) begin
         lsr |= u16550_pkg::LSR_TEMT;
         thr_pend = 1;
      end
      if (mcr[4]) begin
         line_in(tsr);
         return 0;
      end
      return 1;
   endfunction

   function logic [7:0] reg_read(logic [2:0] a);
      logic [7:0] v;
      v = '0;
      case (u16550_pkg::reg_addr_type'(a))
         u16550_pkg::ADDR_RBR: begin
            if (lcr & u16550_pkg::LCR_DLAB) v = dll[7:0];
            else if (fcr & u16550_pkg::FCR_FE) begin
               if (rx_cnt != 0) begin
                  v = rxq[rx_hd];
                  rx_hd = (rx_hd + 1) % Depth;
                  rx_cnt--;
               end
               if (rx_cnt == 0) lsr &= ~(u16550_pkg::LSR_DR | u16550_pkg::LSR_BI);
               else to_cnt = to_ticks;
               to_pend = 0;
            end else begin
               v = rbr;
               lsr &= ~(u16550_pkg::LSR_DR | u16550_pkg::LSR_BI);
            end
         end
         u16550_pkg::ADDR_IER: v = (lcr & u16550_pkg::LCR_DLAB) ? dll[15:8] : ier;
         u16550_pkg::ADDR_IIR: begin
            v = iir;
            if (v[2:1] == 2'b01) thr_pend = 0;
         end
         u16550_pkg::ADDR_LCR: v = lcr;
         u16550_pkg::ADDR_MCR: v = mcr;
         u16550_pkg::ADDR_LSR: begin
            v = lsr;
            lsr &= ~(u16550_pkg::LSR_BI | u16550_pkg::LSR_OE);
         end
         u16550_pkg::ADDR_MSR: begin
            if (mcr[4]) v = {mcr[3:2], mcr[0], mcr[1], 4'h0};
            else begin
               v = msr;
               msr &= 8'hF0;
            end
         end
         default: v = scr;
      endcase
      return v;
   endfunction

   function void fcr_write(logic [7:0] v);
      if (v == fcr) return;
      if ((v ^ fcr) & u16550_pkg::FCR_FE) v |= u16550_pkg::FCR_XFR | u16550_pkg::FCR_RFR;
      if (v & u16550_pkg::FCR_RFR) begin
         to_cnt = 0; to_pend = 0; rx_cnt = 0; rx_hd = 0;
         lsr &= ~(u16550_pkg::LSR_DR | u16550_pkg::LSR_BI);
      end
      if (v & u16550_pkg::FCR_XFR) begin
         tx_cnt = 0;
         tx_hd = 0;
      end
      if (v & u16550_pkg::FCR_FE) begin
         iir |= u16550_pkg::IIR_FIFO;
         case (v[7:6])
            2'b00: trig = 1;
            2'b01: trig = 4;
            2'b10: trig = 8;
            default: trig = 14;
         endcase
      end else iir &= ~u16550_pkg::IIR_FIFO;
      fcr = v & u16550_pkg::FCR_MASK;
   endfunction

   function bit reg_write(logic [2:0] a, logic [7:0] v);
      case (u16550_pkg::reg_addr_type'(a))
         u16550_pkg::ADDR_RBR: begin
            if (lcr & u16550_pkg::LCR_DLAB) begin
               dll[7:0] = v;
               return 0;
            end
            thr = v;
            if (fcr & u16550_pkg::FCR_FE) begin
               if (tx_cnt >= Depth) begin   // overrun drops the oldest byte
                  tx_hd = (tx_hd + 1) % Depth;
                  tx_cnt--;
               end
               txq[(tx_hd + tx_cnt) % Depth] = v;
               tx_cnt++;
               lsr &= ~u16550_pkg::LSR_TEMT;
            end
            thr_pend = 0;
            lsr &= ~u16550_pkg::LSR_THRE;
            return shift_out();
         end
         u16550_pkg::ADDR_IER: begin
            if (lcr & u16550_pkg::LCR_DLAB) dll[15:8] = v;
            else begin
               ier = v & 8'h0F;
               if (lsr & u16550_pkg::LSR_THRE) thr_pend = 1;
            end
         end
         u16550_pkg::ADDR_IIR: fcr_write(v);
         u16550_pkg::ADDR_LCR: lcr = v;
         u16550_pkg::ADDR_MCR: mcr = v & 8'h1F;
         u16550_pkg::ADDR_SCR: scr = v;
         default: ;
      endcase
      return 0;
   endfunction

   function uart_rsp_type uart_predict(logic [2:0] kind, logic [2:0] a, logic [7:0] wd,
                                       logic [7:0] rb);
      uart_rsp_type r;
      bit sent;
      int sp;
      r.rd = '0;
      sent = 0;
      case (kind)
         u16550_pkg::REQ_READ:  r.rd = reg_read(a);
         u16550_pkg::REQ_WRITE: sent = reg_write(a, wd);
         u16550_pkg::REQ_LINE:  line_in(rb);
         u16550_pkg::REQ_BREAK: begin
            rbr = '0;
            rx_push(8'h00);
            lsr |= u16550_pkg::LSR_BI | u16550_pkg::LSR_DR;
         end
         u16550_pkg::REQ_TICK: begin
            if (to_cnt != 0) begin
               to_cnt--;
               if (to_cnt == 0 && rx_cnt != 0) to_pend = 1;
            end
         end
         default: ;
      endcase
      eval_irq();
      if (fcr & u16550_pkg::FCR_FE) begin
         if (rx_cnt >= Depth) sp = 0;
         else if (rx_cnt <= trig) sp = trig - rx_cnt;
         else sp = 1;
      end else sp = (lsr & u16550_pkg::LSR_DR) ? 0 : 1;
      r.irq   = !iir[0];
      r.txv   = sent;
      r.txb   = sent ? tsr : 8'h00;
      r.brk   = lcr[6];
      r.space = 5'(sp);
      return r;
   endfunction

   // ---- transfer monitor and checker ----
   always @(posedge clock) begin : monitor
      uart_rsp_type e;
      if (!reset) begin
         if (req_valid && req_ready) begin
            e = uart_predict(req_type, req_reg_addr, req_write_data, req_rx_byte);
            if (chk_rd_en) e.rd = chk_rd;
            pending_rsp.push_back(e);
            n_items++;
         end
         if (rsp_valid && rsp_ready) begin
            n_rsp++;
            if (pending_rsp.size() == 0) begin
               $error("response transfer with nothing outstanding");
               fails++;
            end else begin
               e = pending_rsp.pop_front();
               if (rsp_read_data !== e.rd) begin
                  $error("read_data exp %h got %h", e.rd, rsp_read_data); fails++;
               end
               if (rsp_irq !== e.irq) begin
                  $error("irq exp %b got %b", e.irq, rsp_irq); fails++;
               end
               if (rsp_tx_valid !== e.txv) begin
                  $error("tx_valid exp %b got %b", e.txv, rsp_tx_valid); fails++;
               end
               if (rsp_tx_byte !== e.txb) begin
                  $error("tx_byte exp %h got %h", e.txb, rsp_tx_byte); fails++;
               end
               if (rsp_break_out !== e.brk) begin
                  $error("break_out exp %b got %b", e.brk, rsp_break_out); fails++;
               end
               if (rsp_rx_space !== e.space) begin
                  $error("rx_space exp %0d got %0d", e.space, rsp_rx_space); fails++;
               end
               n_tx  += e.txv;
               n_irq += e.irq;
            end
         end
      end
   end

   // receiver: random stalls plus a single long hold-off
   always @(posedge clock) begin
      if (hold_len != 0) begin
         hold_cnt = hold_len;
         hold_len = 0;
      end
      if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_ready <= 1'b0;
      end else rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("FAIL uart_16550_register_model_top");
         $finish;
      end
   end

   task automatic send_item(logic [2:0] kind, logic [2:0] a, logic [7:0] wd, logic [7:0] rb,
                            bit typed = 0, logic [7:0] typed_rd = '0);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= kind;
      req_reg_addr   <= a;
      req_write_data <= wd;
      req_rx_byte    <= rb;
      chk_rd_en      <= typed;
      chk_rd         <= typed_rd;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      chk_rd_en <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (SettleGap) @(posedge clock);
   endtask

   task automatic set_timeout(logic [15:0] v);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      to_ticks = v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic random_item();
      int          pick;
      logic [2:0]  kind, a;
      logic [7:0]  wd;
      pick = $urandom_range(99);
      a    = 3'($urandom_range(7));
      wd   = 8'($urandom);
      if (pick < 30) kind = u16550_pkg::REQ_READ;
      else if (pick < 58) begin
         kind = u16550_pkg::REQ_WRITE;
         // keep DLAB mostly clear so data and IER stay reachable
         if (u16550_pkg::reg_addr_type'(a) == u16550_pkg::ADDR_LCR &&
             $urandom_range(9) < 8) wd[7] = 1'b0;
         if (u16550_pkg::reg_addr_type'(a) == u16550_pkg::ADDR_IIR &&
             $urandom_range(9) < 7) wd[0] = 1'b1;
         if (u16550_pkg::reg_addr_type'(a) == u16550_pkg::ADDR_MCR &&
             $urandom_range(1)) wd[4] = 1'b0;
      end else if (pick < 78) kind = u16550_pkg::REQ_LINE;
      else if (pick < 83) kind = u16550_pkg::REQ_BREAK;
      else if (pick < 97) kind = u16550_pkg::REQ_TICK;
      else kind = 3'($urandom_range(REQ_SPARE_LAST, REQ_SPARE_FIRST));
      send_item(kind, a, wd, 8'($urandom));
   endtask

   dir_row_type dir_rows[] = '{
      '{u16550_pkg::REQ_READ,  u16550_pkg::ADDR_IIR, 8'h00, 8'h00, 1, 8'h01},
      '{u16550_pkg::REQ_READ,  u16550_pkg::ADDR_LSR, 8'h00, 8'h00, 1, 8'h60},
      '{u16550_pkg::REQ_READ,  u16550_pkg::ADDR_MSR, 8'h00, 8'h00, 1, 8'hB0},
      '{u16550_pkg::REQ_READ,  u16550_pkg::ADDR_MCR, 8'h00, 8'h00, 1, 8'h08},
      '{u16550_pkg::REQ_WRITE, u16550_pkg::ADDR_SCR, 8'hFF, 8'h00, 0, 8'h00},
      '{u16550_pkg::REQ_READ,  u16550_pkg::ADDR_SCR, 8'h00, 8'h00, 1, 8'hFF},
      '{u16550_pkg::REQ_WRITE, u16550_pkg::ADDR_LCR, 8'h80, 8'h00, 0, 8'h00},
      '{u16550_pkg::REQ_READ,  u16550_pkg::ADDR_RBR, 8'h00, 8'h00, 1, 8'h0C},
      '{u16550_pkg::REQ_WRITE, u16550_pkg::ADDR_RBR, 8'h34, 8'h00, 0, 8'h00},
      '{u16550_pkg::REQ_WRITE, u16550_pkg::ADDR_IER, 8'h12, 8'h00, 0, 8'h00},
      '{u16550_pkg::REQ_READ,  u16550_pkg::ADDR_IER, 8'h00, 8'h00, 1, 8'h12},
      '{u16550_pkg::REQ_WRITE, u16550_pkg::ADDR_LCR, 8'h40, 8'h00, 0, 8'h00},
      '{u16550_pkg::REQ_LINE,  u16550_pkg::ADDR_RBR, 8'h00, 8'hFF, 0, 8'h00},
      '{u16550_pkg::REQ_LINE,  u16550_pkg::ADDR_RBR, 8'h00, 8'h00, 0, 8'h00},
      '{u16550_pkg::REQ_WRITE, u16550_pkg::ADDR_IER, 8'h0F, 8'h00, 0, 8'h00},
      '{u16550_pkg::REQ_WRITE, u16550_pkg::ADDR_IIR, 8'hC1, 8'h00, 0, 8'h00},
      '{u16550_pkg::REQ_LINE,  u16550_pkg::ADDR_RBR, 8'h00, 8'hA5, 0, 8'h00},
      '{u16550_pkg::REQ_BREAK, u16550_pkg::ADDR_RBR, 8'h00, 8'h00, 0, 8'h00},
      '{u16550_pkg::REQ_TICK,  u16550_pkg::ADDR_RBR, 8'h00, 8'h00, 0, 8'h00},
      '{u16550_pkg::REQ_READ,  u16550_pkg::ADDR_RBR, 8'h00, 8'h00, 0, 8'h00},
      '{u16550_pkg::REQ_WRITE, u16550_pkg::ADDR_RBR, 8'hAA, 8'h00, 0, 8'h00},
      '{u16550_pkg::REQ_WRITE, u16550_pkg::ADDR_MCR, 8'h1F, 8'h00, 0, 8'h00},
      '{u16550_pkg::REQ_WRITE, u16550_pkg::ADDR_RBR, 8'h55, 8'h00, 0, 8'h00},
      '{REQ_SPARE_LAST,        u16550_pkg::ADDR_SCR, 8'hFF, 8'hFF, 0, 8'h00},
      '{u16550_pkg::REQ_READ,  u16550_pkg::ADDR_MSR, 8'h00, 8'h00, 0, 8'h00},
      '{u16550_pkg::REQ_READ,  u16550_pkg::ADDR_LSR, 8'h00, 8'h00, 0, 8'h00},
      '{u16550_pkg::REQ_WRITE, u16550_pkg::ADDR_IIR, 8'h00, 8'h00, 0, 8'h00}
   };

   initial begin
      int idles[4]  = '{0, 70, 0, 28};
      int stalls[4] = '{0, 0, 70, 28};
      logic [15:0] tmo[4] = '{16'd3, 16'd65535, 16'd1, 16'd40};
      model_reset();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (dir_rows[i])
         send_item(dir_rows[i].kind, dir_rows[i].addr, dir_rows[i].wd, dir_rows[i].rb,
                   dir_rows[i].typed, dir_rows[i].typed_rd);
      for (int ph = 0; ph < 4; ph++) begin
         set_timeout(tmo[ph]);
         idle_pct  = idles[ph];
         stall_pct = stalls[ph];
         // bring the UART into FIFO mode with interrupts enabled, then randomize
         send_item(u16550_pkg::REQ_WRITE, u16550_pkg::ADDR_LCR, 8'h03, 8'h00);
         send_item(u16550_pkg::REQ_WRITE, u16550_pkg::ADDR_IIR, 8'(8'h07 | (ph << 6)), 8'h00);
         send_item(u16550_pkg::REQ_WRITE, u16550_pkg::ADDR_IER, 8'h0F, 8'h00);
         for (int n = 0; n < 345; n++) begin
            if (ph == 0 && n == 100) hold_len = 300;   // fills the pipe, stalls req side
            random_item();
         end
      end
      drain();
      set_timeout(u16550_pkg::TimeoutTicksReset);
      drain();
      $display("Covered %0d items, %0d responses, %0d line transmits, %0d with irq high.",
               n_items, n_rsp, n_tx, n_irq);
      $display("Timeout settings 1, 3, 40 and 65535 under four idle/stall mixes.");
      if (fails == 0 && pending_rsp.size() == 0)
         $display("PASS uart_16550_register_model_top");
      else
         $display("FAIL uart_16550_register_model_top");
      $finish;
   end

endmodule
